>>> hw/rtl/cdsc_pkg.sv
// ----------------------------------------------------------------------------
// Calendar date step counter package
// Shared types, command codes and calendar helper functions.
// ----------------------------------------------------------------------------
package cdsc_pkg;

    localparam logic [13:0] MaxYear     = 14'd9999;
    localparam logic [13:0] DefaultYear = 14'd1900;
    localparam logic [3:0]  MonthJan    = 4'd1;
    localparam logic [3:0]  MonthFeb    = 4'd2;
    localparam logic [3:0]  MonthDec    = 4'd12;
    localparam logic [4:0]  DayFirst    = 5'd1;
    localparam logic [4:0]  DecLength   = 5'd31;
    localparam logic [12:0] Recip100    = 13'd5243;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_ADD  = 2'd1,
        MODE_SUB  = 2'd2,
        MODE_CMP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_mode       mode;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [15:0] day_count;
    } t_req;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic        stored_greater;
        logic        dates_equal;
        logic        load_rejected;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic run_done;
        logic out_free;
    } t_status;

    // The year is scaled by 2^19/100. A multiple of 100 leaves a fraction
    // below 2^12, any other year leaves one above it, and the integer part
    // is the quotient by 100.
    function automatic logic f_is_leap(input logic [13:0] year);
        logic [26:0] prod;
        logic        div100;
        prod   = 27'(year) * 27'(Recip100);
        div100 = (prod[18:12] == 7'd0);
        return div100 ? (prod[20:19] == 2'd0) : (year[1:0] == 2'd0);
    endfunction

    function automatic logic [4:0] f_month_len(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            MonthFeb:                                    len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/cdsc_req_if.sv
// ----------------------------------------------------------------------------
// Calendar date step counter request channel
// Valid/ready channel that carries one command request.
// ----------------------------------------------------------------------------
interface cdsc_req_if;
    logic          valid;
    logic          ready;
    cdsc_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/cdsc_rsp_if.sv
// ----------------------------------------------------------------------------
// Calendar date step counter response channel
// Valid/ready channel that carries one command result.
// ----------------------------------------------------------------------------
interface cdsc_rsp_if;
    logic          valid;
    logic          ready;
    cdsc_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/cdsc_ctrl.sv
// ----------------------------------------------------------------------------
// Calendar date step counter controller
// Sequences capture, day stepping and result write for one request.
// ----------------------------------------------------------------------------
module cdsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  cdsc_pkg::t_status i_status,
    output cdsc_pkg::t_cmd    o_cmd
);
    import cdsc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_status.run_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            ST_RUN: begin
                o_cmd.step = !i_status.run_done;
            end
            ST_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: o_req_ready = 1'b0;
        endcase
    end

endmodule

>>> hw/rtl/cdsc_datapath.sv
// ----------------------------------------------------------------------------
// Calendar date step counter datapath
// Date registers, day counter, one-day step unit and result register.
// ----------------------------------------------------------------------------
module cdsc_datapath #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cdsc_pkg::t_cmd    i_cmd,
    output cdsc_pkg::t_status o_status,
    input  cdsc_pkg::t_req    i_req_data,
    output cdsc_pkg::t_rsp    o_rsp_data,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready
);
    import cdsc_pkg::*;

    localparam int ExtWidth = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    t_req                   r_in;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [13:0]            r_year;
    logic [3:0]             r_month;
    logic [4:0]             r_day;
    t_rsp                   r_rsp;
    logic                   r_rsp_valid;

    logic [13:0]   n_year;
    logic [3:0]    n_month;
    logic [4:0]    n_day;
    t_rsp          n_rsp;
    logic [ExtWidth-1:0] count_ext;
    logic          cur_leap;
    logic          in_leap;
    logic [4:0]    cur_len;
    logic [4:0]    prev_len;
    logic          load_ok;
    logic          stepping;
    logic          greater;
    logic          equal;

    assign count_ext = ExtWidth'(i_req_data.day_count);
    assign cur_leap  = f_is_leap(r_year);
    assign in_leap   = f_is_leap(r_in.in_year);
    assign cur_len   = f_month_len(cur_leap, r_month);
    assign prev_len  = f_month_len(cur_leap, r_month - 4'd1);
    assign stepping  = (r_in.mode == MODE_ADD) || (r_in.mode == MODE_SUB);

    assign load_ok = (r_in.in_year <= MaxYear) && (r_in.in_month >= MonthJan)
                     && (r_in.in_month <= MonthDec) && (r_in.in_day >= DayFirst)
                     && (r_in.in_day <= f_month_len(in_leap, r_in.in_month));

    assign o_status.run_done = !stepping || (r_count == '0);
    assign o_status.out_free = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        greater = 1'b0;
        equal   = 1'b0;
        if (r_year != r_in.in_year) begin
            greater = r_year > r_in.in_year;
        end else if (r_month != r_in.in_month) begin
            greater = r_month > r_in.in_month;
        end else if (r_day != r_in.in_day) begin
            greater = r_day > r_in.in_day;
        end else begin
            equal = 1'b1;
        end
    end

    always_comb begin
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        if (i_cmd.step) begin
            if (r_in.mode == MODE_ADD) begin
                if (r_day < cur_len) begin
                    n_day = r_day + 5'd1;
                end else begin
                    n_day = DayFirst;
                    if (r_month < MonthDec) begin
                        n_month = r_month + 4'd1;
                    end else begin
                        n_month = MonthJan;
                        n_year  = (r_year == MaxYear) ? 14'd0 : r_year + 14'd1;
                    end
                end
            end else begin
                if (r_day > DayFirst) begin
                    n_day = r_day - 5'd1;
                end else if (r_month > MonthJan) begin
                    n_month = r_month - 4'd1;
                    n_day   = prev_len;
                end else begin
                    n_month = MonthDec;
                    n_day   = DecLength;
                    n_year  = (r_year == 14'd0) ? MaxYear : r_year - 14'd1;
                end
            end
        end else if (i_cmd.finish && (r_in.mode == MODE_LOAD)) begin
            if (load_ok) begin
                n_year  = r_in.in_year;
                n_month = r_in.in_month;
                n_day   = r_in.in_day;
            end else begin
                n_year  = DefaultYear;
                n_month = MonthJan;
                n_day   = DayFirst;
            end
        end
    end

    always_comb begin
        n_rsp.out_year       = n_year;
        n_rsp.out_month      = n_month;
        n_rsp.out_day        = n_day;
        n_rsp.stored_greater = (r_in.mode == MODE_CMP) && greater;
        n_rsp.dates_equal    = (r_in.mode == MODE_CMP) && equal;
        n_rsp.load_rejected  = (r_in.mode == MODE_LOAD) && !load_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year      <= DefaultYear;
            r_month     <= MonthJan;
            r_day       <= DayFirst;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_year  <= n_year;
            r_month <= n_month;
            r_day   <= n_day;
            if (i_cmd.capture) begin
                r_count <= count_ext[COUNT_WIDTH-1:0];
            end else if (i_cmd.step) begin
                r_count <= r_count - COUNT_WIDTH'(1);
            end
            if (i_cmd.finish) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_req_data;
        end
        if (i_cmd.finish) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_data  = r_rsp;
    assign o_rsp_valid = r_rsp_valid;

endmodule

>>> hw/rtl/calendar_date_step_counter.sv
// ----------------------------------------------------------------------------
// Calendar date step counter
// Gregorian date register that loads, steps forward or back, and compares.
// ----------------------------------------------------------------------------
//   Channel   Direction   Carries
//   i_req     in          mode, in_year, in_month, in_day, day_count
//   o_rsp     out         out_year, out_month, out_day, three flags
//
// A load or compare goes from idle, which accepts the request, through run to
// done, which writes the result register and returns to idle for the next
// request. An add or subtract stays in run to move the date N days, where N is
// the low COUNT_WIDTH bits of day_count, since the step unit moves one day per cycle.
// A request is accepted while the previous result still waits in the output
// register; the new result is written only once that register is free.
// Reset sets the date to 1900-01-01 and empties the output register.
// ----------------------------------------------------------------------------
module calendar_date_step_counter #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdsc_req_if.sink   i_req,
    cdsc_rsp_if.source o_rsp
);
    import cdsc_pkg::*;

    t_cmd    cmd;
    t_status status;

    cdsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cdsc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_req_data  (i_req.data),
        .o_rsp_data  (o_rsp.data),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule

>>> hw/rtl/cdsc_checker.sv
// ----------------------------------------------------------------------------
// Calendar date step counter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cdsc_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_rsp_valid,
    input logic           i_rsp_ready,
    input cdsc_pkg::t_rsp i_rsp_data
);
    import cdsc_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("Result changed or dropped while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("Result valid right after reset.");

    a_reject_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.load_rejected |->
            (i_rsp_data.out_year == DefaultYear) && (i_rsp_data.out_month == MonthJan)
            && (i_rsp_data.out_day == DayFirst))
        else $error("Rejected load did not give the default date.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> $onehot0({i_rsp_data.stored_greater, i_rsp_data.dates_equal,
                                  i_rsp_data.load_rejected}))
        else $error("More than one result flag set.");

    a_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.out_year <= MaxYear)
            && (i_rsp_data.out_month >= MonthJan) && (i_rsp_data.out_month <= MonthDec)
            && (i_rsp_data.out_day >= DayFirst) && (i_rsp_data.out_day <= DecLength))
        else $error("Result date out of range.");

endmodule

bind calendar_date_step_counter cdsc_checker u_cdsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

>>> verif/tb_calendar_date_step_counter.sv
// ----------------------------------------------------------------------------
// Calendar date step counter testbench
// Drives load, add, subtract and compare requests through the request
// channel, first from a directed table of calendar corner cases and then at
// random, with idle cycles on both channels except in the last phase. A
// behavioral date model predicts every result the table does not give, and
// each returned result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module tb_calendar_date_step_counter;
    import cdsc_pkg::*;

    localparam int unsigned CYCLE_DAYS       = 3652425;
    localparam int unsigned CYCLE_LIMIT      = 4000000;
    localparam int unsigned RANDOM_PER_PHASE = 450;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned DIRECTED_ROWS    = 25;
    localparam int unsigned MONTH_DAYS [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    cdsc_req_if  req_if ();
    cdsc_rsp_if  rsp_if ();

    logic [13:0] cal_year  = DefaultYear;
    logic [3:0]  cal_month = MonthJan;
    logic [4:0]  cal_day   = DayFirst;
    t_rsp        expected_dates [$];

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned checked_count  = 0;
    int unsigned rejected_count = 0;
    int unsigned equal_count    = 0;
    int unsigned later_count    = 0;
    int unsigned mode_count [4] = '{0, 0, 0, 0};
    int unsigned src_idle_pct   = 0;
    int unsigned snk_idle_pct   = 0;

    // Flag columns of the typed results are stored_greater, dates_equal and
    // load_rejected. Rows with typed set to zero are left to the date model.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{{MODE_CMP,  14'd1900,  4'd1,  5'd1,  16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b010}},
        '{{MODE_LOAD, 14'd9999,  4'd12, 5'd31, 16'hFFFF},  1'b1, {14'd9999, 4'd12, 5'd31, 3'b000}},
        '{{MODE_ADD,  14'd0,     4'd0,  5'd0,  16'd1},     1'b1, {14'd0,    4'd1,  5'd1,  3'b000}},
        '{{MODE_SUB,  14'd16383, 4'd15, 5'd31, 16'd1},     1'b1, {14'd9999, 4'd12, 5'd31, 3'b000}},
        '{{MODE_LOAD, 14'd0,     4'd2,  5'd29, 16'd0},     1'b1, {14'd0,    4'd2,  5'd29, 3'b000}},
        '{{MODE_ADD,  14'd0,     4'd0,  5'd0,  16'd1},     1'b0, '0},
        '{{MODE_LOAD, 14'd16383, 4'd15, 5'd31, 16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd10000, 4'd1,  5'd1,  16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd2023,  4'd2,  5'd29, 16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd1900,  4'd2,  5'd29, 16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd2000,  4'd2,  5'd29, 16'd0},     1'b1, {14'd2000, 4'd2,  5'd29, 3'b000}},
        '{{MODE_LOAD, 14'd2024,  4'd0,  5'd10, 16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd2024,  4'd13, 5'd1,  16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd2024,  4'd4,  5'd0,  16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd2024,  4'd4,  5'd31, 16'd0},     1'b1, {14'd1900, 4'd1,  5'd1,  3'b001}},
        '{{MODE_LOAD, 14'd2024,  4'd4,  5'd30, 16'd0},     1'b1, {14'd2024, 4'd4,  5'd30, 3'b000}},
        '{{MODE_CMP,  14'd16383, 4'd15, 5'd31, 16'd0},     1'b1, {14'd2024, 4'd4,  5'd30, 3'b000}},
        '{{MODE_CMP,  14'd0,     4'd0,  5'd0,  16'd0},     1'b1, {14'd2024, 4'd4,  5'd30, 3'b100}},
        '{{MODE_CMP,  14'd2024,  4'd4,  5'd31, 16'd0},     1'b1, {14'd2024, 4'd4,  5'd30, 3'b000}},
        '{{MODE_CMP,  14'd2024,  4'd4,  5'd30, 16'd0},     1'b1, {14'd2024, 4'd4,  5'd30, 3'b010}},
        '{{MODE_ADD,  14'd2024,  4'd4,  5'd30, 16'd0},     1'b1, {14'd2024, 4'd4,  5'd30, 3'b000}},
        '{{MODE_ADD,  14'd0,     4'd0,  5'd0,  16'hFFFF},  1'b0, '0},
        '{{MODE_SUB,  14'd0,     4'd0,  5'd0,  16'hFFFF},  1'b0, '0},
        '{{MODE_LOAD, 14'd2100,  4'd2,  5'd28, 16'd0},     1'b1, {14'd2100, 4'd2,  5'd28, 3'b000}},
        '{{MODE_ADD,  14'd0,     4'd0,  5'd0,  16'd1},     1'b0, '0}
    };

    calendar_date_step_counter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit leap_year(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned year, input int unsigned month);
        if (month < 1 || month > 12) begin
            return 0;
        end
        return MONTH_DAYS[month] + ((month == 2 && leap_year(year)) ? 1 : 0);
    endfunction

    // Year 0 is a leap year, so the years below a given one hold
    // ceil(y/4) multiples of four, less the centuries, plus the 400s.
    function automatic int unsigned days_before(input int unsigned year);
        return 365 * year + (year + 3) / 4 - (year + 99) / 100 + (year + 399) / 400;
    endfunction

    function automatic int unsigned stored_day_number();
        int unsigned num;
        num = days_before(cal_year);
        for (int unsigned k = 1; k < cal_month && k <= 12; k++) begin
            num += days_in_month(cal_year, k);
        end
        return num + cal_day - 1;
    endfunction

    function automatic void set_from_day_number(input int unsigned num);
        int unsigned year;
        int unsigned month;
        year  = num / 366;
        month = 1;
        while (year < MaxYear && days_before(year + 1) <= num) begin
            year++;
        end
        num -= days_before(year);
        while (month < 12 && num >= days_in_month(year, month)) begin
            num -= days_in_month(year, month);
            month++;
        end
        cal_year  = 14'(year);
        cal_month = 4'(month);
        cal_day   = 5'(num + 1);
    endfunction

    function automatic t_rsp apply_command(input t_req req);
        t_rsp rsp;
        rsp = '0;
        case (req.mode)
            MODE_LOAD: begin
                if (req.in_year <= MaxYear &&
                        req.in_day >= 1 && req.in_day <= days_in_month(req.in_year, req.in_month)) begin
                    cal_year  = req.in_year;
                    cal_month = req.in_month;
                    cal_day   = req.in_day;
                end else begin
                    cal_year  = DefaultYear;
                    cal_month = MonthJan;
                    cal_day   = DayFirst;
                    rsp.load_rejected = 1'b1;
                end
            end
            MODE_ADD: begin
                set_from_day_number((stored_day_number() + req.day_count) % CYCLE_DAYS);
            end
            MODE_SUB: begin
                set_from_day_number((stored_day_number() + CYCLE_DAYS - req.day_count) % CYCLE_DAYS);
            end
            default: begin
                if (cal_year != req.in_year) begin
                    rsp.stored_greater = cal_year > req.in_year;
                end else if (cal_month != req.in_month) begin
                    rsp.stored_greater = cal_month > req.in_month;
                end else if (cal_day != req.in_day) begin
                    rsp.stored_greater = cal_day > req.in_day;
                end else begin
                    rsp.dates_equal = 1'b1;
                end
            end
        endcase
        rsp.out_year  = cal_year;
        rsp.out_month = cal_month;
        rsp.out_day   = cal_day;
        return rsp;
    endfunction

    function automatic void random_valid_date(output logic [13:0] year, output logic [3:0] month,
                                              output logic [4:0] day);
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 15) begin
            year = 14'($urandom_range(3));
        end else if (pick < 30) begin
            year = 14'($urandom_range(9999, 9990));
        end else if (pick < 40) begin
            year = 14'(100 * $urandom_range(99));
        end else begin
            year = 14'($urandom_range(9999));
        end
        month = 4'($urandom_range(12, 1));
        len   = days_in_month(year, month);
        pick  = $urandom_range(9);
        if (pick < 2) begin
            day = DayFirst;
        end else if (pick < 4) begin
            day = 5'(len);
        end else begin
            day = 5'($urandom_range(len, 1));
        end
    endfunction

    // Stepping moves the date one day at a time, so long counts are kept rare.
    function automatic logic [15:0] random_day_count();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 1) begin
            return 16'($urandom);
        end else if (pick < 10) begin
            return 16'($urandom_range(4095));
        end else if (pick < 35) begin
            return 16'($urandom_range(511));
        end
        return 16'($urandom_range(40));
    endfunction

    function automatic t_req random_request();
        t_req        req;
        int unsigned pick;
        req.mode      = MODE_CMP;
        req.in_year   = 14'($urandom);
        req.in_month  = 4'($urandom);
        req.in_day    = 5'($urandom);
        req.day_count = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 22) begin
            req.mode = MODE_LOAD;
            if ($urandom_range(99) < 85) begin
                random_valid_date(req.in_year, req.in_month, req.in_day);
            end
        end else if (pick < 72) begin
            req.mode      = (pick < 47) ? MODE_ADD : MODE_SUB;
            req.day_count = random_day_count();
        end else begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                req.in_year  = cal_year;
                req.in_month = cal_month;
                req.in_day   = cal_day;
                if (pick >= 35) begin
                    case ($urandom_range(2))
                        0: req.in_year  = $urandom_range(1) ? req.in_year + 1'b1 : req.in_year - 1'b1;
                        1: req.in_month = $urandom_range(1) ? req.in_month + 1'b1 : req.in_month - 1'b1;
                        default: req.in_day = $urandom_range(1) ? req.in_day + 1'b1 : req.in_day - 1'b1;
                    endcase
                end
            end else if (pick < 85) begin
                random_valid_date(req.in_year, req.in_month, req.in_day);
            end
        end
        return req;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got, input int unsigned want);
        mismatch_count++;
        $display("MISMATCH cycle %0d: %s got %0d, expected %0d", cycle_count, what, got, want);
    endtask

    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (expected_dates.size() == 0) begin
            flag_mismatch("result with no request pending, year", got.out_year, 0);
            return;
        end
        want = expected_dates.pop_front();
        checked_count++;
        rejected_count += want.load_rejected;
        equal_count    += want.dates_equal;
        later_count    += want.stored_greater;
        if (got.out_year !== want.out_year) begin
            flag_mismatch("out_year", got.out_year, want.out_year);
        end
        if (got.out_month !== want.out_month) begin
            flag_mismatch("out_month", got.out_month, want.out_month);
        end
        if (got.out_day !== want.out_day) begin
            flag_mismatch("out_day", got.out_day, want.out_day);
        end
        if (got.stored_greater !== want.stored_greater) begin
            flag_mismatch("stored_greater", got.stored_greater, want.stored_greater);
        end
        if (got.dates_equal !== want.dates_equal) begin
            flag_mismatch("dates_equal", got.dates_equal, want.dates_equal);
        end
        if (got.load_rejected !== want.load_rejected) begin
            flag_mismatch("load_rejected", got.load_rejected, want.load_rejected);
        end
    endtask

    task automatic send_request(input t_req req, input bit typed, input t_rsp typed_rsp);
        t_rsp predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= req;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predicted = apply_command(req);
        expected_dates.push_back(typed ? typed_rsp : predicted);
        mode_count[req.mode]++;
    endtask

    initial begin : result_sink
        rsp_if.ready <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) begin
                check_result(rsp_if.data);
            end
            rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, expected_dates.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int unsigned idle_plan [3][2];
        idle_plan = '{'{26, 58}, '{58, 26}, '{0, 0}};
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = idle_plan[0][0];
        snk_idle_pct = idle_plan[0][1];
        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
        end

        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = idle_plan[phase][0];
            snk_idle_pct = idle_plan[phase][1];
            repeat (RANDOM_PER_PHASE) begin
                send_request(random_request(), 1'b0, '0);
            end
        end
        req_if.valid <= 1'b0;

        while (expected_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads, %0d adds, %0d subtracts and %0d compares in %0d cycles.",
                 mode_count[MODE_LOAD], mode_count[MODE_ADD], mode_count[MODE_SUB],
                 mode_count[MODE_CMP], cycle_count);
        $display("Checked %0d results: %0d rejected loads, %0d equal and %0d later compares.",
                 checked_count, rejected_count, equal_count, later_count);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> calendar_date_step_counter.f
hw/rtl/cdsc_pkg.sv
hw/rtl/cdsc_req_if.sv
hw/rtl/cdsc_rsp_if.sv
hw/rtl/cdsc_ctrl.sv
hw/rtl/cdsc_datapath.sv
hw/rtl/calendar_date_step_counter.sv
hw/rtl/cdsc_checker.sv
verif/tb_calendar_date_step_counter.sv
